// ----- sv/code_lock_with_lockout_macros.svh -----
// Assertion macros shared by the code lock RTL files.
`ifndef CODE_LOCK_WITH_LOCKOUT_MACROS_SVH
`define CODE_LOCK_WITH_LOCKOUT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("code lock assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("code lock assertion failed");

`endif

// ----- sv/cll_pkg.sv -----
// Package with types, codes and constants of the code lock.
package cll_pkg;

	localparam int CODE_DIGITS = 3;
	localparam int CODE_W = 2 * CODE_DIGITS;
	localparam int ENTRY_WAIT = CODE_DIGITS + 1;
	localparam int STEP_W = $clog2(ENTRY_WAIT + 1);
	localparam int TICK_W = 16;
	localparam int CNT_W = 4;
	localparam int FLASH_W = 6;

	localparam logic [FLASH_W-1:0] ACK_TICKS = FLASH_W'(10);
	localparam logic [FLASH_W-1:0] WRONG_TICKS = FLASH_W'(30);
	localparam logic [FLASH_W-1:0] GRANT_TICKS = FLASH_W'(50);
	localparam logic [CNT_W-1:0] FAIL_MAX = '1;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_DIGIT = 2'd1;
	localparam logic [1:0] MODE_ENTER = 2'd2;

	localparam logic [1:0] PH_NORMAL = 2'd0;
	localparam logic [1:0] PH_WARNING = 2'd1;
	localparam logic [1:0] PH_LOCKDOWN = 2'd2;

	localparam logic [1:0] FL_NONE = 2'd0;
	localparam logic [1:0] FL_ACK = 2'd1;
	localparam logic [1:0] FL_WRONG = 2'd2;
	localparam logic [1:0] FL_GRANT = 2'd3;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_GRANT = 3'd1;
	localparam logic [2:0] EV_WRONG = 3'd2;
	localparam logic [2:0] EV_TIMEOUT = 3'd3;
	localparam logic [2:0] EV_ADMIN = 3'd4;

	localparam int NUM_REGS = 8;
	localparam int APB_AW = $clog2(NUM_REGS * 4);
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam logic [REG_IDX_W-1:0] REG_OWNER_PIN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MASTER_PIN = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ENTER_TIMEOUT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WARNING_TICKS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WARN_HALF = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LOCK_HALF = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_WARN_AFTER = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_LOCK_AFTER = 3'd7;

	typedef struct packed {
		logic [CODE_W-1:0] owner_pin;
		logic [CODE_W-1:0] master_pin;
		logic [TICK_W-1:0] enter_timeout_ticks;
		logic [TICK_W-1:0] warning_ticks;
		logic [TICK_W-1:0] warn_half_ticks;
		logic [TICK_W-1:0] lock_half_ticks;
		logic [CNT_W-1:0] warn_after;
		logic [CNT_W-1:0] lock_after;
	} cll_cfg_t;

	typedef struct packed {
		logic alarm_led;
		logic wrong_led;
		logic blocked_led;
		logic [1:0] lock_state;
		logic [2:0] event_res;
	} cll_res_t;

endpackage

// ----- sv/cll_ifs.sv -----
// Request and result channel interfaces of the code lock.
interface cll_req_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic [1:0] digit;

	modport source (output valid, output mode, output digit, input ready);
	modport sink (input valid, input mode, input digit, output ready);
endinterface

interface cll_res_if;
	logic valid;
	logic ready;
	logic alarm_led;
	logic wrong_led;
	logic blocked_led;
	logic [1:0] lock_state;
	logic [2:0] event_res;

	modport source (output valid, output alarm_led, output wrong_led, output blocked_led,
		output lock_state, output event_res, input ready);
	modport sink (input valid, input alarm_led, input wrong_led, input blocked_led,
		input lock_state, input event_res, output ready);
endinterface

// ----- sv/code_lock_with_lockout.sv -----
// Top level of the keypad code lock with warning and lockdown phases.
//
// channel  dir  handshake     payload
// cmd      in   valid/ready   mode, digit
// res      out  valid/ready   alarm_led, wrong_led, blocked_led, lock_state, event_res
// apb      in   psel/penable  paddr, pwdata, prdata (eight registers)
//
// One request per cycle while the result is not stalled, set by the input register and the result register alone.
// A result is registered in the result register when its request leaves the input register.
// The lock state is updated in the cycle a request leaves the input register.
// A stalled result holds both stages; the input register still takes a request when empty.
// Reset clears the lock state and loads the default register values.
module code_lock_with_lockout
	import cll_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	cll_req_if.sink           cmd,
	cll_res_if.source         res
);

`include "code_lock_with_lockout_macros.svh"

	cll_cfg_t cfg;
	cll_res_t step_res;
	cll_res_t res_q;
	logic valid_s1, res_valid_q, adv, fire;
	logic [1:0] mode_s1, digit_s1;

	cll_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign adv = !res_valid_q || res.ready;
	assign fire = valid_s1 && adv;
	assign cmd.ready = !valid_s1 || adv;

	cll_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.mode(mode_s1),
		.digit(digit_s1),
		.cfg(cfg),
		.res(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.ready)
				valid_s1 <= cmd.valid;
			if (adv)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			mode_s1 <= cmd.mode;
			digit_s1 <= cmd.digit;
		end
		if (fire)
			res_q <= step_res;
	end

	assign res.valid = res_valid_q;
	assign res.alarm_led = res_q.alarm_led;
	assign res.wrong_led = res_q.wrong_led;
	assign res.blocked_led = res_q.blocked_led;
	assign res.lock_state = res_q.lock_state;
	assign res.event_res = res_q.event_res;

	`CLL_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(mode_s1))

endmodule

// ----- sv/cll_regs.sv -----
// APB configuration register file of the code lock.
module cll_regs
	import cll_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cll_cfg_t          cfg
);

	cll_cfg_t cfg_q;
	logic wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign idx = paddr[APB_AW-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.owner_pin <= CODE_W'(27);
			cfg_q.master_pin <= CODE_W'(61);
			cfg_q.enter_timeout_ticks <= TICK_W'(500);
			cfg_q.warning_ticks <= TICK_W'(1000);
			cfg_q.warn_half_ticks <= TICK_W'(50);
			cfg_q.lock_half_ticks <= TICK_W'(100);
			cfg_q.warn_after <= CNT_W'(2);
			cfg_q.lock_after <= CNT_W'(3);
		end else if (wr_en) begin
			case (idx)
				REG_OWNER_PIN: cfg_q.owner_pin <= pwdata[CODE_W-1:0];
				REG_MASTER_PIN: cfg_q.master_pin <= pwdata[CODE_W-1:0];
				REG_ENTER_TIMEOUT: cfg_q.enter_timeout_ticks <= pwdata[TICK_W-1:0];
				REG_WARNING_TICKS: cfg_q.warning_ticks <= pwdata[TICK_W-1:0];
				REG_WARN_HALF: cfg_q.warn_half_ticks <= pwdata[TICK_W-1:0];
				REG_LOCK_HALF: cfg_q.lock_half_ticks <= pwdata[TICK_W-1:0];
				REG_WARN_AFTER: cfg_q.warn_after <= pwdata[CNT_W-1:0];
				REG_LOCK_AFTER: cfg_q.lock_after <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OWNER_PIN: prdata = 32'(cfg_q.owner_pin);
			REG_MASTER_PIN: prdata = 32'(cfg_q.master_pin);
			REG_ENTER_TIMEOUT: prdata = 32'(cfg_q.enter_timeout_ticks);
			REG_WARNING_TICKS: prdata = 32'(cfg_q.warning_ticks);
			REG_WARN_HALF: prdata = 32'(cfg_q.warn_half_ticks);
			REG_LOCK_HALF: prdata = 32'(cfg_q.lock_half_ticks);
			REG_WARN_AFTER: prdata = 32'(cfg_q.warn_after);
			REG_LOCK_AFTER: prdata = 32'(cfg_q.lock_after);
			default: prdata = '0;
		endcase
	end

endmodule

// ----- sv/cll_core.sv -----
// Lock state registers and the combinational update for one request.
module cll_core
	import cll_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [1:0] mode,
	input  logic [1:0] digit,
	input  cll_cfg_t   cfg,
	output cll_res_t   res
);

`include "code_lock_with_lockout_macros.svh"

	logic [1:0] phase_q, n_phase;
	logic [STEP_W-1:0] step_q, n_step;
	logic [CODE_W-1:0] digits_q, n_digits;
	logic [TICK_W-1:0] wait_q, n_wait;
	logic [CNT_W-1:0] fail_q, n_fail;
	logic warned_q, n_warned;
	logic [TICK_W-1:0] ptimer_q, n_ptimer;
	logic [TICK_W-1:0] btimer_q, n_btimer;
	logic blink_q, n_blink;
	logic [FLASH_W-1:0] ftimer_q, n_ftimer;
	logic [1:0] fkind_q, n_fkind;
	logic [2:0] ev;

	logic [TICK_W-1:0] warn_len, warn_half, lock_half, pt_inc, bt_inc;
	logic [FLASH_W-1:0] ft_dec;
	logic [STEP_W-1:0] step_inc;
	logic press_ok;

	assign warn_len = (cfg.warning_ticks == '0) ? TICK_W'(1) : cfg.warning_ticks;
	assign warn_half = (cfg.warn_half_ticks == '0) ? TICK_W'(1) : cfg.warn_half_ticks;
	assign lock_half = (cfg.lock_half_ticks == '0) ? TICK_W'(1) : cfg.lock_half_ticks;
	assign pt_inc = ptimer_q + TICK_W'(1);
	assign bt_inc = btimer_q + TICK_W'(1);
	assign ft_dec = (ftimer_q != '0) ? ftimer_q - FLASH_W'(1) : ftimer_q;
	assign step_inc = step_q + STEP_W'(1);
	assign press_ok = (fkind_q == FL_NONE) && (phase_q != PH_WARNING);

	always_comb begin
		n_phase = phase_q;
		n_step = step_q;
		n_digits = digits_q;
		n_wait = wait_q;
		n_fail = fail_q;
		n_warned = warned_q;
		n_ptimer = ptimer_q;
		n_btimer = btimer_q;
		n_blink = blink_q;
		n_ftimer = ftimer_q;
		n_fkind = fkind_q;
		ev = EV_NONE;
		case (mode)
			MODE_TICK: begin
				if (fkind_q != FL_NONE) begin
					n_ftimer = ft_dec;
					if (ft_dec == '0) begin
						n_fkind = FL_NONE;
						if (fkind_q == FL_WRONG) begin
							if (fail_q >= cfg.warn_after && !warned_q) begin
								n_phase = PH_WARNING;
								n_warned = 1'b1;
								n_ptimer = '0;
								n_btimer = '0;
								n_blink = 1'b1;
							end else if (fail_q >= cfg.lock_after && warned_q) begin
								n_phase = PH_LOCKDOWN;
								n_btimer = '0;
								n_blink = 1'b0;
							end
						end
					end
				end else if (phase_q == PH_WARNING) begin
					if (pt_inc >= warn_len || pt_inc == '0) begin
						n_phase = PH_NORMAL;
						n_blink = 1'b0;
						n_btimer = '0;
						n_ptimer = '0;
					end else begin
						n_ptimer = pt_inc;
						if (bt_inc >= warn_half) begin
							n_blink = ~blink_q;
							n_btimer = '0;
						end else begin
							n_btimer = bt_inc;
						end
					end
				end else begin
					if (phase_q == PH_LOCKDOWN) begin
						if (bt_inc >= lock_half) begin
							n_blink = ~blink_q;
							n_btimer = '0;
						end else begin
							n_btimer = bt_inc;
						end
					end
					if (step_q == STEP_W'(ENTRY_WAIT)) begin
						if (wait_q <= TICK_W'(1)) begin
							n_step = '0;
							n_wait = '0;
							ev = EV_TIMEOUT;
						end else begin
							n_wait = wait_q - TICK_W'(1);
						end
					end
				end
			end
			MODE_DIGIT: begin
				if (digit != 2'd0 && press_ok && step_q != '0
						&& step_q < STEP_W'(ENTRY_WAIT)) begin
					n_digits = CODE_W'({digits_q, digit});
					n_step = step_inc;
					if (step_inc == STEP_W'(ENTRY_WAIT))
						n_wait = cfg.enter_timeout_ticks;
					n_fkind = FL_ACK;
					n_ftimer = ACK_TICKS;
				end
			end
			MODE_ENTER: begin
				if (press_ok) begin
					if (step_q == '0) begin
						n_step = STEP_W'(1);
						n_digits = '0;
					end else if (step_q == STEP_W'(ENTRY_WAIT)) begin
						n_step = '0;
						n_wait = '0;
						if (phase_q == PH_LOCKDOWN) begin
							if (digits_q == cfg.master_pin) begin
								n_phase = PH_NORMAL;
								n_fail = '0;
								n_warned = 1'b0;
								n_blink = 1'b0;
								n_btimer = '0;
								ev = EV_ADMIN;
							end else begin
								ev = EV_WRONG;
							end
						end else if (digits_q == cfg.owner_pin) begin
							n_fail = '0;
							n_warned = 1'b0;
							n_fkind = FL_GRANT;
							n_ftimer = GRANT_TICKS;
							ev = EV_GRANT;
						end else begin
							if (fail_q != FAIL_MAX)
								n_fail = fail_q + CNT_W'(1);
							n_fkind = FL_WRONG;
							n_ftimer = WRONG_TICKS;
							ev = EV_WRONG;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.alarm_led = (n_fkind == FL_GRANT) || (n_phase == PH_LOCKDOWN && n_fkind != FL_WRONG);
		res.wrong_led = (n_fkind == FL_ACK) || (n_fkind == FL_WRONG);
		res.blocked_led = (n_phase != PH_NORMAL) ? n_blink : 1'b0;
		res.lock_state = n_phase;
		res.event_res = ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			step_q <= '0;
			digits_q <= '0;
			wait_q <= '0;
			fail_q <= '0;
			warned_q <= 1'b0;
			ptimer_q <= '0;
			btimer_q <= '0;
			blink_q <= 1'b0;
			ftimer_q <= '0;
			fkind_q <= FL_NONE;
		end else if (fire) begin
			phase_q <= n_phase;
			step_q <= n_step;
			digits_q <= n_digits;
			wait_q <= n_wait;
			fail_q <= n_fail;
			warned_q <= n_warned;
			ptimer_q <= n_ptimer;
			btimer_q <= n_btimer;
			blink_q <= n_blink;
			ftimer_q <= n_ftimer;
			fkind_q <= n_fkind;
		end
	end

	`CLL_ASSERT_NOW(a_flash_timer, 1'b1, (fkind_q == FL_NONE) == (ftimer_q == '0))
	`CLL_ASSERT_NOW(a_warn_marked, phase_q == PH_WARNING, warned_q)
	`CLL_ASSERT_NEXT(a_idle_state_hold, !fire, $stable(phase_q) && $stable(step_q))

endmodule
